@@ rtl/sbpp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sbpp_pkg;

  typedef enum logic [1:0] {
    MODE_DATA  = 2'd0,
    MODE_BEGIN = 2'd1,
    MODE_START = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    FMT_GRAY  = 3'd0,
    FMT_RGB   = 3'd1,
    FMT_RED   = 3'd2,
    FMT_GREEN = 3'd3,
    FMT_BLUE  = 3'd4
  } frame_format_t;

  typedef enum logic [1:0] {
    DEPTH_1   = 2'd0,
    DEPTH_8   = 2'd1,
    DEPTH_16  = 2'd2,
    DEPTH_BAD = 2'd3
  } depth_t;

  typedef enum logic [1:0] {
    CFG_FRAME_FORMAT    = 2'd0,
    CFG_DEPTH_CODE      = 2'd1,
    CFG_PIXELS_PER_LINE = 2'd2,
    CFG_LINE_COUNT      = 2'd3
  } cfg_index_t;

  localparam logic [15:0] ALPHA16   = 16'hFFFF;
  localparam logic [31:0] ALPHA8    = 32'hFF00_0000;
  localparam logic [15:0] COORD_MAX = 16'hFFFF;

endpackage

`default_nettype wire

@@ rtl/scan_byte_pixel_packer_core.sv @@
// Path: an accepted byte is held in the input register; the pixel word that it completes
//   is then registered in the result register that drives the out_ ports.
// Throughput: one byte per cycle while no stalled result holds the input register;
//   state updates in the same pass as the result.
// Reset: synchronous, active low; clears control, counters, byte store and config.
`timescale 1ns / 1ps
`default_nettype none

module scan_byte_pixel_packer_core
  import sbpp_pkg::*;
#(
  parameter int unsigned MAX_BYTES_PER_PIXEL = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pixel_x,
  output logic [15:0]      out_pixel_y,
  output logic [63:0]      out_pixel_value,
  output logic [7:0]       out_byte_enable,
  output logic             out_grew,
  output logic             out_unsupported
);

  localparam logic [2:0] MaxBytes = 3'(MAX_BYTES_PER_PIXEL);

  // configuration
  logic [2:0]  fmt_r;
  logic [1:0]  depth_r;
  logic [15:0] ppl_r;
  logic [15:0] lines_r;

  // input register
  logic       s1_v_r;
  logic [1:0] s1_mode_r;
  logic [7:0] s1_byte_r;

  // frame state
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] held_r, held_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic        par_r, par_nxt;
  logic [7:0]  store_r [MAX_BYTES_PER_PIXEL];
  logic        store_we;

  // result register
  logic        o_v_r, o_v_nxt;
  logic [15:0] o_x_r, o_y_r;
  logic [63:0] o_val_r;
  logic [7:0]  o_be_r;
  logic        o_grew_r, o_bad_r;

  logic        prod;
  logic [15:0] r_x, r_y;
  logic [63:0] r_val;
  logic [7:0]  r_be;
  logic        r_grew, r_bad;

  logic        adv;
  logic        s1_ld;
  logic [15:0] lw;
  logic        grow_hit;
  logic [16:0] held_sum;
  logic [15:0] held_grown;
  logic [15:0] col_inc;
  logic        wrap;
  logic [15:0] row_inc;
  logic [16:0] mono_col;
  logic        mono_wrap;
  logic [2:0]  need;
  logic        bad;
  logic [2:0]  lane;
  logic [2:0]  slot_inc;
  logic [7:0]  view [6];

  assign adv      = !o_v_r || !out_stall;
  // an empty input register takes a word even while the result is held
  assign s1_ld    = !s1_v_r || adv;
  assign in_stall = s1_v_r && !adv;

  assign lw         = (ppl_r == 16'd0) ? 16'd1 : ppl_r;
  assign grow_hit   = row_r >= held_r;
  assign held_sum   = {1'b0, held_r} + {1'b0, lw};
  assign held_grown = held_sum[16] ? COORD_MAX : held_sum[15:0];
  assign col_inc    = col_r + 16'd1;
  assign wrap       = col_inc >= lw;
  assign row_inc    = (row_r == COORD_MAX) ? COORD_MAX : row_r + 16'd1;
  assign mono_col   = {1'b0, col_r} + 17'd8;
  assign mono_wrap  = mono_col >= {1'b0, lw};
  assign slot_inc   = slot_r + 3'd1;

  always_comb begin
    need = 3'd1;
    if (fmt_r == FMT_GRAY && depth_r == DEPTH_16) need = 3'd2;
    if (fmt_r == FMT_RGB) need = (depth_r == DEPTH_16) ? 3'd6 : 3'd3;
  end

  assign bad = (fmt_r > FMT_BLUE) || (depth_r == DEPTH_BAD) ||
               (fmt_r != FMT_GRAY && depth_r == DEPTH_1) || (need > MaxBytes);

  always_comb begin
    if (depth_r == DEPTH_8) begin
      lane = (fmt_r == FMT_RED) ? 3'd2 : ((fmt_r == FMT_GREEN) ? 3'd1 : 3'd0);
    end else begin
      lane = 3'((fmt_r - 3'd2) << 1) + {2'b00, par_r};
    end
  end

  // store contents as seen after this byte lands; entries past the store read zero
  for (genvar i = 0; i < 6; i++) begin : g_view
    if (i < MAX_BYTES_PER_PIXEL) begin : g_have
      assign view[i] = (slot_r == 3'(i)) ? s1_byte_r : store_r[i];
    end else begin : g_none
      assign view[i] = 8'd0;
    end
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    held_nxt = held_r;
    slot_nxt = slot_r;
    par_nxt  = par_r;
    store_we = 1'b0;
    prod     = 1'b0;
    r_x      = 16'd0;
    r_y      = 16'd0;
    r_val    = 64'd0;
    r_be     = 8'd0;
    r_grew   = 1'b0;
    r_bad    = 1'b0;
    if (s1_v_r && adv) begin
      unique case (s1_mode_r)
        MODE_BEGIN, MODE_START: begin
          col_nxt  = 16'd0;
          row_nxt  = 16'd0;
          slot_nxt = 3'd0;
          par_nxt  = 1'b0;
          if (s1_mode_r == MODE_START) begin
            held_nxt = (lines_r != 16'd0) ? lines_r : lw;
          end
        end
        MODE_DATA: begin
          if (bad) begin
            prod  = 1'b1;
            r_bad = 1'b1;
          end else if (fmt_r >= FMT_RED) begin
            prod   = 1'b1;
            r_grew = grow_hit;
            r_x    = col_r;
            r_y    = row_r;
            r_val  = {56'd0, s1_byte_r} << {lane, 3'b000};
            r_be   = 8'd1 << lane;
            if (grow_hit) held_nxt = held_grown;
            if (depth_r == DEPTH_8 || par_r) begin
              col_nxt = wrap ? 16'd0 : col_inc;
              row_nxt = wrap ? row_inc : row_r;
            end
            if (depth_r != DEPTH_8) par_nxt = !par_r;
          end else if (need == 3'd1) begin
            prod   = 1'b1;
            r_grew = grow_hit;
            r_x    = col_r;
            r_y    = row_r;
            r_val  = {56'd0, s1_byte_r};
            r_be   = 8'h01;
            if (grow_hit) held_nxt = held_grown;
            if (depth_r == DEPTH_1) begin
              col_nxt = mono_wrap ? 16'd0 : mono_col[15:0];
              row_nxt = mono_wrap ? row_inc : row_r;
            end else begin
              col_nxt = wrap ? 16'd0 : col_inc;
              row_nxt = wrap ? row_inc : row_r;
            end
          end else begin
            store_we = slot_r < MaxBytes;
            if (slot_inc < need) begin
              slot_nxt = slot_inc;
            end else begin
              slot_nxt = 3'd0;
              prod     = 1'b1;
              r_grew   = grow_hit;
              r_x      = col_r;
              r_y      = row_r;
              if (grow_hit) held_nxt = held_grown;
              col_nxt = wrap ? 16'd0 : col_inc;
              row_nxt = wrap ? row_inc : row_r;
              if (fmt_r == FMT_GRAY) begin
                r_val = {48'd0, view[1], view[0]};
                r_be  = 8'h03;
              end else if (depth_r == DEPTH_8) begin
                r_val = {32'd0, ALPHA8 | {8'd0, view[0], view[1], view[2]}};
                r_be  = 8'h0F;
              end else begin
                r_val = {ALPHA16, view[5], view[4], view[3], view[2], view[1], view[0]};
                r_be  = 8'hFF;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign o_v_nxt = adv ? (s1_v_r && prod) : o_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_GRAY;
      depth_r <= DEPTH_8;
      ppl_r   <= 16'd1;
      lines_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_FORMAT:    fmt_r   <= cfg_wdata[2:0];
        CFG_DEPTH_CODE:      depth_r <= cfg_wdata[1:0];
        CFG_PIXELS_PER_LINE: ppl_r   <= cfg_wdata;
        CFG_LINE_COUNT:      lines_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
      col_r  <= 16'd0;
      row_r  <= 16'd0;
      held_r <= 16'd0;
      slot_r <= 3'd0;
      par_r  <= 1'b0;
    end else begin
      if (s1_ld) s1_v_r <= in_valid;
      o_v_r  <= o_v_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      held_r <= held_nxt;
      slot_r <= slot_nxt;
      par_r  <= par_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld && in_valid) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_data_byte;
    end
    if (adv && s1_v_r && prod) begin
      o_x_r    <= r_x;
      o_y_r    <= r_y;
      o_val_r  <= r_val;
      o_be_r   <= r_be;
      o_grew_r <= r_grew;
      o_bad_r  <= r_bad;
    end
  end

  for (genvar i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        store_r[i] <= 8'd0;
      end else if (store_we && slot_r == 3'(i)) begin
        store_r[i] <= s1_byte_r;
      end
    end
  end

  assign out_valid       = o_v_r;
  assign out_pixel_x     = o_x_r;
  assign out_pixel_y     = o_y_r;
  assign out_pixel_value = o_val_r;
  assign out_byte_enable = o_be_r;
  assign out_grew        = o_grew_r;
  assign out_unsupported = o_bad_r;

`ifndef SYNTHESIS
  a_bad_no_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_bad_r) |-> (o_be_r == 8'd0 && !o_grew_r))
    else $error("unsupported word carries enables");

  a_good_has_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && !o_bad_r) |-> (o_be_r != 8'd0))
    else $error("pixel word with no byte enabled");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < 3'd6)
    else $error("byte slot out of range");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && o_v_r))
    else $error("input stalled with nothing held");
`endif

endmodule

`default_nettype wire

@@ tb/sv/pixel_write_checker.sv @@
`timescale 1ns / 1ps

module pixel_write_checker
  import sbpp_pkg::*;
#(
  parameter int unsigned MAX_BYTES_PER_PIXEL = 6,
  parameter int unsigned MAX_REPORTS         = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_pixel_x,
  input  logic [15:0] out_pixel_y,
  input  logic [63:0] out_pixel_value,
  input  logic [7:0]  out_byte_enable,
  input  logic        out_grew,
  input  logic        out_unsupported,
  output int unsigned fail_count,
  output int unsigned pending_writes
);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [63:0] value;
    logic [7:0]  enable;
    logic        grew;
    logic        unsupported;
  } pixel_write_t;

  pixel_write_t expected_writes[$];

  logic [2:0]  fmt_q;
  depth_t      depth_q;
  logic [15:0] ppl_q;
  logic [15:0] lc_q;

  logic [15:0] column;
  logic [15:0] row;
  logic [15:0] held_height;
  logic [7:0]  byte_store [6];
  logic [2:0]  byte_slot;
  logic        plane_parity;

  initial begin
    fail_count     = 0;
    pending_writes = 0;
  end

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? COORD_MAX : v[15:0];
  endfunction

  // a zero line width counts as one pixel
  function automatic logic [15:0] line_width();
    return (ppl_q == 16'd0) ? 16'd1 : ppl_q;
  endfunction

  function automatic logic check_grow();
    if (row >= held_height) begin
      held_height = sat16({1'b0, held_height} + {1'b0, line_width()});
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void next_pixel();
    column = column + 16'd1;
    if (column >= line_width()) begin
      column = 16'd0;
      row    = sat16({1'b0, row} + 17'd1);
    end
  endfunction

  task automatic predict_write(input logic [1:0] mode, input logic [7:0] b,
                               output logic found, output pixel_write_t w);
    logic [2:0]  need;
    logic [2:0]  lane;
    logic [16:0] col8;
    found = 1'b0;
    w     = '0;
    if (mode == MODE_BEGIN || mode == MODE_START) begin
      column       = 16'd0;
      row          = 16'd0;
      byte_slot    = 3'd0;
      plane_parity = 1'b0;
      if (mode == MODE_START) held_height = (lc_q != 16'd0) ? lc_q : line_width();
      return;
    end
    if (mode != MODE_DATA) return;

    need = 3'd1;
    if (fmt_q == FMT_GRAY && depth_q == DEPTH_16) need = 3'd2;
    if (fmt_q == FMT_RGB) need = (depth_q == DEPTH_16) ? 3'd6 : 3'd3;
    found = 1'b1;
    if (fmt_q > FMT_BLUE || depth_q == DEPTH_BAD ||
        (fmt_q != FMT_GRAY && depth_q == DEPTH_1) || need > MAX_BYTES_PER_PIXEL) begin
      // flag only, state holds
      w.unsupported = 1'b1;
      return;
    end

    if (fmt_q >= FMT_RED) begin
      if (depth_q == DEPTH_8) begin
        lane = (fmt_q == FMT_RED) ? 3'd2 : (fmt_q == FMT_GREEN) ? 3'd1 : 3'd0;
      end else begin
        lane = ((fmt_q - FMT_RED) << 1) + {2'b00, plane_parity};
      end
      w.grew   = check_grow();
      w.x      = column;
      w.y      = row;
      w.value  = 64'(b) << (8 * lane);
      w.enable = 8'd1 << lane;
      if (depth_q == DEPTH_8) begin
        next_pixel();
      end else begin
        // advance after the high byte only
        if (plane_parity) next_pixel();
        plane_parity = ~plane_parity;
      end
    end else if (need == 3'd1) begin
      w.grew   = check_grow();
      w.x      = column;
      w.y      = row;
      w.value  = 64'(b);
      w.enable = 8'h01;
      if (depth_q == DEPTH_1) begin
        // mono column counts bits, eight per word
        col8 = {1'b0, column} + 17'd8;
        if (col8 >= {1'b0, line_width()}) begin
          column = 16'd0;
          row    = sat16({1'b0, row} + 17'd1);
        end else begin
          column = col8[15:0];
        end
      end else begin
        next_pixel();
      end
    end else begin
      if (byte_slot < MAX_BYTES_PER_PIXEL && byte_slot < 3'd6) byte_store[byte_slot] = b;
      byte_slot = byte_slot + 3'd1;
      // a slot left over from a wider format completes the pixel at once
      if (byte_slot < need) begin
        found = 1'b0;
        return;
      end
      byte_slot = 3'd0;
      w.grew    = check_grow();
      w.x       = column;
      w.y       = row;
      if (fmt_q == FMT_GRAY) begin
        w.value  = {48'd0, byte_store[1], byte_store[0]};
        w.enable = 8'h03;
      end else if (depth_q == DEPTH_8) begin
        w.value  = {32'd0, ALPHA8 | {8'd0, byte_store[0], byte_store[1], byte_store[2]}};
        w.enable = 8'h0F;
      end else begin
        w.value  = {ALPHA16, byte_store[5], byte_store[4], byte_store[3],
                    byte_store[2], byte_store[1], byte_store[0]};
        w.enable = 8'hFF;
      end
      next_pixel();
    end
  endtask

  always @(posedge clk) begin
    pixel_write_t exp_w;
    pixel_write_t got_w;
    logic         found;
    if (!rst_n) begin
      fmt_q        = FMT_GRAY;
      depth_q      = DEPTH_8;
      ppl_q        = 16'd1;
      lc_q         = 16'd0;
      column       = 16'd0;
      row          = 16'd0;
      held_height  = 16'd0;
      byte_slot    = 3'd0;
      plane_parity = 1'b0;
      for (int i = 0; i < 6; i++) byte_store[i] = 8'd0;
      expected_writes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_FORMAT:    fmt_q   = cfg_wdata[2:0];
          CFG_DEPTH_CODE:      depth_q = depth_t'(cfg_wdata[1:0]);
          CFG_PIXELS_PER_LINE: ppl_q   = cfg_wdata;
          CFG_LINE_COUNT:      lc_q    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_write(in_mode, in_data_byte, found, exp_w);
        if (found) expected_writes.push_back(exp_w);
      end
      if (out_valid && !out_stall) begin
        got_w = {out_pixel_x, out_pixel_y, out_pixel_value, out_byte_enable,
                 out_grew, out_unsupported};
        if (expected_writes.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected pixel write x=%0d y=%0d value=%h be=%h grew=%b unsup=%b",
                     $realtime, got_w.x, got_w.y, got_w.value, got_w.enable,
                     got_w.grew, got_w.unsupported);
        end else begin
          exp_w = expected_writes.pop_front();
          if (got_w.x !== exp_w.x || got_w.y !== exp_w.y || got_w.value !== exp_w.value ||
              got_w.enable !== exp_w.enable || got_w.grew !== exp_w.grew ||
              got_w.unsupported !== exp_w.unsupported) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: pixel write mismatch", $realtime);
              $display("  exp x=%0d y=%0d value=%h be=%h grew=%b unsup=%b",
                       exp_w.x, exp_w.y, exp_w.value, exp_w.enable,
                       exp_w.grew, exp_w.unsupported);
              $display("  got x=%0d y=%0d value=%h be=%h grew=%b unsup=%b",
                       got_w.x, got_w.y, got_w.value, got_w.enable,
                       got_w.grew, got_w.unsupported);
            end
          end
        end
      end
    end
    pending_writes = expected_writes.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import sbpp_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned SEGMENT_WORDS    = 65;
  localparam int unsigned SEGMENTS         = 8;
  localparam logic [1:0]  MODE_IGNORED     = 2'd3;
  localparam logic [2:0]  FMT_UNDEFINED    = 3'd7;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = CFG_FRAME_FORMAT;
  logic [15:0] cfg_wdata    = 16'd0;
  logic        in_valid     = 1'b0;
  logic [1:0]  in_mode      = MODE_DATA;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_stall    = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [15:0] out_pixel_x;
  logic [15:0] out_pixel_y;
  logic [63:0] out_pixel_value;
  logic [7:0]  out_byte_enable;
  logic        out_grew;
  logic        out_unsupported;

  int unsigned fail_count;
  int unsigned pending_writes;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_hold_req = 1'b0;
  bit          hold_served   = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scan_byte_pixel_packer_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_value (out_pixel_value),
    .out_byte_enable (out_byte_enable),
    .out_grew        (out_grew),
    .out_unsupported (out_unsupported)
  );

  pixel_write_checker check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_value (out_pixel_value),
    .out_byte_enable (out_byte_enable),
    .out_grew        (out_grew),
    .out_unsupported (out_unsupported),
    .fail_count      (fail_count),
    .pending_writes  (pending_writes)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req && !hold_served) begin
      hold_left   = LONG_HOLD_CYCLES;
      hold_served = 1'b1;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("scan_byte_pixel_packer_core verification failed");
      $finish;
    end
  end

  // enter and leave at a falling edge; valid stays high for a back-to-back word
  task automatic send_word(input logic [1:0] mode, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid, wait out the results, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_writes != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [2:0] fmt, input logic [1:0] depth,
                            input logic [15:0] ppl, input logic [15:0] lc);
    wait_drained();
    write_reg(CFG_FRAME_FORMAT, {13'd0, fmt});
    write_reg(CFG_DEPTH_CODE, {14'd0, depth});
    write_reg(CFG_PIXELS_PER_LINE, ppl);
    write_reg(CFG_LINE_COUNT, lc);
    cfg_we <= 1'b0;
  endtask

  task automatic run_segment(input int unsigned n_words);
    logic [2:0]  fmt;
    logic [1:0]  depth;
    logic [15:0] ppl;
    logic [15:0] lc;
    logic [7:0]  b;
    int unsigned r;
    fmt = ($urandom_range(99) < 6) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    if ($urandom_range(99) < 8)
      depth = 2'($urandom_range(3));
    else if (fmt == FMT_GRAY)
      depth = 2'($urandom_range(2));
    else
      depth = 2'($urandom_range(2, 1));
    r = $urandom_range(99);
    if (r < 10)      ppl = 16'd0;
    else if (r < 18) ppl = 16'hFFFF;
    else if (r < 30) ppl = 16'($urandom_range(65535));
    else             ppl = 16'($urandom_range(6, 1));
    r = $urandom_range(99);
    if (r < 30)      lc = 16'd0;
    else if (r < 40) lc = 16'hFFFF;
    else if (r < 50) lc = 16'($urandom_range(65535));
    else             lc = 16'($urandom_range(5, 1));
    set_config(fmt, depth, ppl, lc);
    send_word(($urandom_range(99) < 80) ? MODE_START : MODE_BEGIN, 8'($urandom_range(255)));
    repeat (n_words) begin
      r = $urandom_range(99);
      if (r < 5)       b = 8'h00;
      else if (r < 10) b = 8'hFF;
      else             b = 8'($urandom_range(255));
      // mostly data words; the rest restart frames or are ignored
      if ($urandom_range(99) < 88) send_word(MODE_DATA, b);
      else                         send_word(2'($urandom_range(3, 1)), b);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 37;
    recv_idle_pct = 72;

    // reset settings: gray8, one pixel per line, height zero grows at once
    send_word(MODE_DATA, 8'h00);
    send_word(MODE_DATA, 8'hFF);
    send_word(MODE_IGNORED, 8'h5A);

    set_config(FMT_GRAY, DEPTH_16, 16'd3, 16'd2);
    send_word(MODE_START, 8'h00);
    send_word(MODE_DATA, 8'h34);
    send_word(MODE_DATA, 8'h12);

    set_config(FMT_RGB, DEPTH_8, 16'd2, 16'd0);
    send_word(MODE_BEGIN, 8'hFF);
    send_word(MODE_DATA, 8'hAA);
    send_word(MODE_DATA, 8'h55);
    send_word(MODE_DATA, 8'hFF);

    set_config(FMT_RGB, DEPTH_16, 16'hFFFF, 16'd0);
    send_word(MODE_START, 8'h00);
    send_word(MODE_DATA, 8'h11);
    send_word(MODE_DATA, 8'h22);
    send_word(MODE_DATA, 8'h33);
    send_word(MODE_DATA, 8'h44);
    send_word(MODE_DATA, 8'h55);
    send_word(MODE_DATA, 8'h66);

    // leave an rgb16 pixel partly done, then finish it as gray16
    send_word(MODE_DATA, 8'hA1);
    send_word(MODE_DATA, 8'hA2);
    set_config(FMT_GRAY, DEPTH_16, 16'hFFFF, 16'd0);
    send_word(MODE_DATA, 8'hA3);

    set_config(FMT_RED, DEPTH_8, 16'd0, 16'd0);
    send_word(MODE_DATA, 8'h7E);
    set_config(FMT_BLUE, DEPTH_16, 16'd4, 16'd0);
    send_word(MODE_DATA, 8'h80);
    send_word(MODE_DATA, 8'h01);

    set_config(FMT_GREEN, DEPTH_BAD, 16'd4, 16'd0);
    send_word(MODE_DATA, 8'hC3);
    set_config(FMT_UNDEFINED, DEPTH_8, 16'd4, 16'd0);
    send_word(MODE_DATA, 8'h3C);
    set_config(FMT_GREEN, DEPTH_1, 16'd4, 16'd0);
    send_word(MODE_DATA, 8'h96);

    // mono rows step per word; then a full-width growth saturates the height
    set_config(FMT_GRAY, DEPTH_1, 16'd1, 16'd3);
    send_word(MODE_START, 8'h00);
    send_word(MODE_DATA, 8'h81);
    send_word(MODE_DATA, 8'h42);
    send_word(MODE_DATA, 8'h24);
    set_config(FMT_GRAY, DEPTH_1, 16'hFFFF, 16'd3);
    send_word(MODE_DATA, 8'h18);

    repeat (SEGMENTS) run_segment(SEGMENT_WORDS);

    send_idle_pct = 72;
    recv_idle_pct = 37;
    repeat (SEGMENTS) run_segment(SEGMENT_WORDS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // start the long hold-off from an empty block so the sender keeps offering
    wait_drained();
    long_hold_req = 1'b1;
    repeat (SEGMENTS) run_segment(SEGMENT_WORDS);

    wait_drained();
    if (fail_count == 0 && pending_writes == 0) begin
      $display("scan_byte_pixel_packer_core verification clean");
    end else begin
      $display("scan_byte_pixel_packer_core verification failed");
    end
    $finish;
  end

endmodule
